// ----- hdl/cbs_pkg.sv -----
package cbs_pkg;

    localparam int COORD_W = 32;
    localparam int OFF_W   = 31;
    localparam int IDX_W   = 6;
    localparam int Q_BITS  = 32;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [OFF_W-1:0] LEAD_OFFSET_RST = 31'd32768;

    typedef logic signed [COORD_W-1:0] t_coord;

    // Four control points P0..P3 of one segment, index i holds Pi
    typedef struct packed {
        t_coord [3:0] x;
        t_coord [3:0] y;
    } t_window;

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic             last;
    } t_tag;

    typedef struct packed {
        t_coord x;
        t_coord y;
        t_tag   tag;
    } t_sample;

    // Divisor of the rounded blend: 2 * 6 * S^3
    function automatic longint cbs_divisor(input longint s);
        return 64'sd12 * s * s * s;
    endfunction

    // Width of the offset numerator that feeds the divider
    function automatic int cbs_num_w(input longint s);
        return Q_BITS + $clog2(cbs_divisor(s));
    endfunction

    function automatic int cbs_weight_w(input longint s);
        return $clog2(64'sd4 * s * s * s + 64'sd1);
    endfunction

    // Integer basis weight k at sample u, scaled by 6 S^3
    function automatic longint cbs_weight(input int k, input longint u, input longint s);
        longint r;
        r = s - u;
        unique case (k)
            0:       return r * r * r;
            1:       return 3 * u * u * u - 6 * u * u * s + 4 * s * s * s;
            2:       return -3 * u * u * u + 3 * u * u * s + 3 * u * s * s + s * s * s;
            default: return u * u * u;
        endcase
    endfunction

endpackage

// ----- hdl/cbs_fifo.sv -----
module cbs_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 2
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output logic         o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [W-1:0]     r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(r_wr + 1'b1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(r_rd + 1'b1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= CNT_W'(r_cnt + 1'b1);
            end else if (do_pop && !do_push) begin
                r_cnt <= CNT_W'(r_cnt - 1'b1);
            end
        end
    end

endmodule

// ----- hdl/cbs_front.sv -----
module cbs_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [cbs_pkg::OFF_W-1:0]     i_cfg_wdata,
    input  logic                          i_push,
    input  cbs_pkg::t_coord               i_point_x,
    input  cbs_pkg::t_coord               i_point_y,
    input  logic                          i_curve_start,
    input  logic                          i_q_full,
    output logic                          o_q_push,
    output cbs_pkg::t_window              o_q_win
);

    import cbs_pkg::*;

    logic [OFF_W-1:0]     r_off;
    logic                 r_seen;
    t_coord               r_wx [3];
    t_coord               r_wy [3];
    logic                 accept, load;
    logic signed [COORD_W:0] lo_w, hi_w;
    t_coord               lo_sat, hi_sat;

    function automatic t_coord sat33(input logic signed [COORD_W:0] v);
        if (v[COORD_W] != v[COORD_W-1]) begin
            return v[COORD_W] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
        end
        return v[COORD_W-1:0];
    endfunction

    assign accept = i_push && !i_q_full;
    // first point of a curve, or the first point after reset
    assign load   = i_curve_start || !r_seen;

    always_comb begin
        lo_w   = $signed({i_point_x[COORD_W-1], i_point_x}) - $signed({2'b00, r_off});
        hi_w   = $signed({i_point_x[COORD_W-1], i_point_x}) + $signed({2'b00, r_off});
        lo_sat = sat33(lo_w);
        hi_sat = sat33(hi_w);
    end

    assign o_q_push = accept && !load;

    always_comb begin
        o_q_win.x[0] = r_wx[0];
        o_q_win.x[1] = r_wx[1];
        o_q_win.x[2] = r_wx[2];
        o_q_win.x[3] = i_point_x;
        o_q_win.y[0] = r_wy[0];
        o_q_win.y[1] = r_wy[1];
        o_q_win.y[2] = r_wy[2];
        o_q_win.y[3] = i_point_y;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off  <= LEAD_OFFSET_RST;
            r_seen <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_off <= i_cfg_wdata;
            end
            if (accept) begin
                r_seen <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            if (load) begin
                r_wx[0] <= lo_sat;
                r_wx[1] <= hi_sat;
                r_wx[2] <= i_point_x;
                r_wy[0] <= i_point_y;
                r_wy[1] <= i_point_y;
                r_wy[2] <= i_point_y;
            end else begin
                r_wx[0] <= r_wx[1];
                r_wx[1] <= r_wx[2];
                r_wx[2] <= i_point_x;
                r_wy[0] <= r_wy[1];
                r_wy[1] <= r_wy[2];
                r_wy[2] <= i_point_y;
            end
        end
    end

endmodule

// ----- hdl/cbs_back.sv -----
module cbs_back #(
    parameter int SAMPLES = 64
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_en,
    input  cbs_pkg::t_window                       i_win,
    input  logic                                   i_win_empty,
    output logic                                   o_win_pop,
    output logic                                   o_valid,
    output logic [cbs_pkg::cbs_num_w(SAMPLES)-1:0] o_num_x,
    output logic [cbs_pkg::cbs_num_w(SAMPLES)-1:0] o_num_y,
    output cbs_pkg::t_tag                          o_tag
);

    import cbs_pkg::*;

    localparam int     JW   = $clog2(SAMPLES);
    localparam int     WW   = cbs_weight_w(SAMPLES);
    localparam int     NW   = cbs_num_w(SAMPLES);
    localparam int     PW   = WW + COORD_W + 1;
    localparam int     SW   = PW + 1;
    localparam int     AW   = NW + 8;
    localparam longint D    = 64'sd6 * SAMPLES * SAMPLES * SAMPLES;
    // rounding half plus a bias of 2^31 quotients keeps the numerator positive
    localparam longint OFFS = D + (D <<< 32);

    logic [3:0][WW-1:0] rom [SAMPLES];

    for (genvar gu = 0; gu < SAMPLES; gu++) begin : g_rom
        for (genvar gk = 0; gk < 4; gk++) begin : g_w
            assign rom[gu][gk] = WW'(cbs_weight(gk, gu, SAMPLES));
        end
    end

    // sequencer
    logic          r_busy;
    logic [JW-1:0] r_j;
    t_window       r_win;
    logic          at_end, take, issue;

    assign at_end    = (r_j == JW'(SAMPLES - 1));
    assign take      = i_en && (!r_busy || at_end) && !i_win_empty;
    assign issue     = i_en && r_busy;
    assign o_win_pop = take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_j    <= '0;
        end else if (i_en) begin
            if (!r_busy || at_end) begin
                r_busy <= !i_win_empty;
            end
            if (r_busy) begin
                r_j <= at_end ? '0 : JW'(r_j + 1'b1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_win <= i_win;
        end
    end

    // blend pipeline
    logic                 r_v1, r_v2, r_v3, r_v4;
    logic [3:0][WW-1:0]   r_w1;
    t_window              r_p1;
    t_tag                 r_t1, r_t2, r_t3, r_t4;
    logic signed [PW-1:0] r_mx [4];
    logic signed [PW-1:0] r_my [4];
    logic signed [SW-1:0] r_sx01, r_sx23, r_sy01, r_sy23;
    logic [NW-1:0]        r_nx, r_ny;
    logic signed [AW-1:0] ax, ay;

    always_comb begin
        ax = ((AW'(r_sx01) + AW'(r_sx23)) <<< 1) + AW'(OFFS);
        ay = ((AW'(r_sy01) + AW'(r_sy23)) <<< 1) + AW'(OFFS);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= issue;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_w1     <= rom[r_j];
            r_p1     <= r_win;
            r_t1.idx <= IDX_W'(r_j);
            r_t1.last <= at_end;
            for (int i = 0; i < 4; i++) begin
                r_mx[i] <= PW'($signed({1'b0, r_w1[i]})) * PW'(r_p1.x[i]);
                r_my[i] <= PW'($signed({1'b0, r_w1[i]})) * PW'(r_p1.y[i]);
            end
            r_t2   <= r_t1;
            r_sx01 <= SW'(r_mx[0]) + SW'(r_mx[1]);
            r_sx23 <= SW'(r_mx[2]) + SW'(r_mx[3]);
            r_sy01 <= SW'(r_my[0]) + SW'(r_my[1]);
            r_sy23 <= SW'(r_my[2]) + SW'(r_my[3]);
            r_t3   <= r_t2;
            r_nx   <= ax[NW-1:0];
            r_ny   <= ay[NW-1:0];
            r_t4   <= r_t3;
        end
    end

    assign o_valid = r_v4;
    assign o_num_x = r_nx;
    assign o_num_y = r_ny;
    assign o_tag   = r_t4;

endmodule

// ----- hdl/cbs_div.sv -----
module cbs_div #(
    parameter int SAMPLES = 64
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_en,
    input  logic                                   i_valid,
    input  logic [cbs_pkg::cbs_num_w(SAMPLES)-1:0] i_num_x,
    input  logic [cbs_pkg::cbs_num_w(SAMPLES)-1:0] i_num_y,
    input  cbs_pkg::t_tag                          i_tag,
    output logic                                   o_valid,
    output cbs_pkg::t_coord                        o_x,
    output cbs_pkg::t_coord                        o_y,
    output cbs_pkg::t_tag                          o_tag
);

    import cbs_pkg::*;

    localparam int     NW    = cbs_num_w(SAMPLES);
    localparam longint M     = cbs_divisor(SAMPLES);
    localparam int     LM    = NW - Q_BITS;
    localparam int     SH    = LM - 1;
    localparam int     PRW   = 2 * Q_BITS + 1;
    localparam int     RW    = LM + 2;
    // reciprocal of the divisor, scaled so that it lands in [2^31, 2^32)
    localparam longint RECIP = (64'sd1 <<< (SH + Q_BITS)) / M;

    logic [PRW-1:0]    prod_x, prod_y;
    logic [NW-1:0]     qm_x, qm_y;
    logic [NW-1:0]     diff_x, diff_y;
    logic [1:0]        corr_x, corr_y;

    logic              r_v1, r_v2, r_v3;
    t_tag              r_t1, r_t2, r_t3;
    logic [NW-1:0]     r_n1x, r_n1y;
    logic [Q_BITS-1:0] r_e1x, r_e1y, r_e2x, r_e2y;
    logic [RW-1:0]     r_r2x, r_r2y;
    logic [Q_BITS-1:0] r_qx, r_qy;

    // the estimate is at most three below the quotient
    function automatic logic [1:0] fixup(input logic [RW-1:0] rem);
        logic [1:0] c;
        c = 2'd0;
        if (rem >= RW'(M)) begin
            c = 2'd1;
        end
        if (rem >= RW'(2 * M)) begin
            c = 2'd2;
        end
        if (rem >= RW'(3 * M)) begin
            c = 2'd3;
        end
        return c;
    endfunction

    always_comb begin
        prod_x = PRW'(i_num_x[NW-1:SH]) * PRW'(RECIP);
        prod_y = PRW'(i_num_y[NW-1:SH]) * PRW'(RECIP);
        qm_x   = NW'(r_e1x) * NW'(M);
        qm_y   = NW'(r_e1y) * NW'(M);
        diff_x = r_n1x - qm_x;
        diff_y = r_n1y - qm_y;
        corr_x = fixup(r_r2x);
        corr_y = fixup(r_r2y);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_e1x <= Q_BITS'(prod_x >> Q_BITS);
            r_e1y <= Q_BITS'(prod_y >> Q_BITS);
            r_n1x <= i_num_x;
            r_n1y <= i_num_y;
            r_t1  <= i_tag;
            r_e2x <= r_e1x;
            r_e2y <= r_e1y;
            r_r2x <= RW'(diff_x);
            r_r2y <= RW'(diff_y);
            r_t2  <= r_t1;
            r_qx  <= r_e2x + Q_BITS'(corr_x);
            r_qy  <= r_e2y + Q_BITS'(corr_y);
            r_t3  <= r_t2;
        end
    end

    // remove the 2^31 bias
    assign o_valid = r_v3;
    assign o_x     = {~r_qx[Q_BITS-1], r_qx[Q_BITS-2:0]};
    assign o_y     = {~r_qy[Q_BITS-1], r_qy[Q_BITS-2:0]};
    assign o_tag   = r_t3;

endmodule

// ----- hdl/cubic_bspline_sampler.sv -----
// Uniform cubic B-spline sampler.
// Input queue side: drive a control point word (i_point_x, i_point_y, i_curve_start)
// with push; it is taken at a clock edge where push is high and full is low.
// A point flagged as a curve start (or the first point after reset) only
// loads the window with two lead points, x -/+ lead_offset, and produces nothing.
// Every later point closes a four point window and yields SAMPLES sample words.
// Result queue side: while empty is low the oldest sample word sits on o_sample_*;
// pop takes it. o_segment_last marks the sample with index SAMPLES-1.
// Configuration: i_cfg_we writes lead_offset (UQ15.16, reset 0.5); write only idle.
// Throughput: one sample word per cycle while the result queue is not full, set
// by the single shared blend and divide pipeline. Up to two windows wait in
// a queue, so points keep flowing while the back end works on earlier ones.
// Path from acceptance of a point to its first sample word on the result
// ports: window queue, weight read, multiply, two adds, three divide stages,
// result queue.
// Reset clears the queues, the sequencer and the curve-started flag and restores
// lead_offset. When the receiver stops popping, the result queue fills and the
// back pipeline holds; the window queue then fills and full rises.
module cubic_bspline_sampler #(
    parameter int SAMPLES = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [30:0]        i_cfg_wdata,
    input  logic               push,
    output logic               full,
    input  logic signed [31:0] i_point_x,
    input  logic signed [31:0] i_point_y,
    input  logic               i_curve_start,
    output logic               empty,
    input  logic               pop,
    output logic signed [31:0] o_sample_x,
    output logic signed [31:0] o_sample_y,
    output logic [5:0]         o_sample_index,
    output logic               o_segment_last
);

    import cbs_pkg::*;

    localparam int NW = cbs_num_w(SAMPLES);

    // front to back window queue
    logic    wq_push, wq_full, wq_empty, wq_pop;
    t_window wq_in, wq_out;

    // back end and divider
    logic          en;
    logic          num_v;
    logic [NW-1:0] num_x, num_y;
    t_tag          num_tag;
    logic          div_v;
    t_coord        div_x, div_y;
    t_tag          div_tag;

    // result queue
    logic    oq_full;
    t_sample oq_in, oq_out;

    cbs_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_push        (push),
        .i_point_x     (i_point_x),
        .i_point_y     (i_point_y),
        .i_curve_start (i_curve_start),
        .i_q_full      (wq_full),
        .o_q_push      (wq_push),
        .o_q_win       (wq_in)
    );

    assign full = wq_full;

    cbs_fifo #(
        .W     ($bits(t_window)),
        .DEPTH (QUEUE_DEPTH)
    ) u_win_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (wq_push),
        .i_data  (wq_in),
        .o_full  (wq_full),
        .i_pop   (wq_pop),
        .o_data  (wq_out),
        .o_empty (wq_empty)
    );

    // hold the whole back pipeline while its last stage cannot drain
    assign en = !(div_v && oq_full);

    cbs_back #(
        .SAMPLES (SAMPLES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (en),
        .i_win       (wq_out),
        .i_win_empty (wq_empty),
        .o_win_pop   (wq_pop),
        .o_valid     (num_v),
        .o_num_x     (num_x),
        .o_num_y     (num_y),
        .o_tag       (num_tag)
    );

    cbs_div #(
        .SAMPLES (SAMPLES)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (num_v),
        .i_num_x (num_x),
        .i_num_y (num_y),
        .i_tag   (num_tag),
        .o_valid (div_v),
        .o_x     (div_x),
        .o_y     (div_y),
        .o_tag   (div_tag)
    );

    assign oq_in.x   = div_x;
    assign oq_in.y   = div_y;
    assign oq_in.tag = div_tag;

    cbs_fifo #(
        .W     ($bits(t_sample)),
        .DEPTH (QUEUE_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (div_v && !oq_full),
        .i_data  (oq_in),
        .o_full  (oq_full),
        .i_pop   (pop),
        .o_data  (oq_out),
        .o_empty (empty)
    );

    assign o_sample_x     = oq_out.x;
    assign o_sample_y     = oq_out.y;
    assign o_sample_index = oq_out.tag.idx;
    assign o_segment_last = oq_out.tag.last;

    // a curve start word only loads the window
    a_start_no_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push && !full && i_curve_start |-> !wq_push)
        else $error("curve start word pushed a window");

    // samples of one segment leave in index order
    a_index_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop && !empty && !o_segment_last |=>
            empty || (o_sample_index == IDX_W'($past(o_sample_index) + 1'b1)))
        else $error("sample index did not advance by one");

    // the last flag sits on the final index only
    a_last_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_segment_last |-> o_sample_index == IDX_W'(SAMPLES - 1))
        else $error("segment_last on a wrong index");

endmodule
